// File: design/swrsi_pkg.sv
// ----------------------------------------------------------------------------
// swrsi_pkg - shared types and constants of the sliding window RSI block
// Widths of the price path, running sums and divider, plus the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package swrsi_pkg;

  // window geometry
  localparam int MAX_WINDOW = 256;
  localparam int RING_DEPTH = MAX_WINDOW - 1;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int WIN_W      = 9;
  localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
  localparam int EFF_W      = (FILL_W > WIN_W) ? FILL_W : WIN_W;

  // price and sum widths
  localparam int PRICE_W = 32;
  localparam int DELTA_W = PRICE_W + 1;
  localparam int SUM_W   = PRICE_W + PTR_W;

  // scaling: value = (100 * 2^16 * gain + total/2) / total
  localparam int SCALE_W = 7;
  localparam int FRAC_W  = 16;
  localparam int P_W     = SUM_W + SCALE_W;
  localparam int NUM_W   = P_W + FRAC_W;
  localparam int Q_W     = 23;
  localparam logic [Q_W-1:0] FULL_SCALE = Q_W'(6553600);

  // divider
  localparam int DIV_STEPS = Q_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(15);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_UPD,
    ST_PREP,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } sw_state_t;

  typedef enum logic [1:0] {
    RK_INVALID,
    RK_FULL,
    RK_ZERO,
    RK_DIVIDE
  } res_kind_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic prep;
    logic load;
    logic step;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    res_kind_t kind;
  } dp_stat_t;

endpackage

// File: design/sliding_window_rsi.sv
// ----------------------------------------------------------------------------
// sliding_window_rsi - simple-average RSI over a sliding window of closes
// Top level: joins the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one closing price per beat.
//   Output channel out_valid/out_ready returns one result beat per input
//   beat: out_rsi_value (0..100 with 16 fractional bits) and out_rsi_valid,
//   which is low until the window holds two closes.
//   cfg_wr_en/cfg_wr_data set the window size (closes, period plus one)
//   and empty the window; write only while the block is idle.
//   One beat is worked at a time. Between acceptance and the next acceptance,
//   a beat that needs the divide goes through ring read, sum update,
//   scaling, 23 restoring-divider steps and the output load. Beats with no
//   loss, no gain or too few closes skip the divider.
//   The divider is the loop that sets the rate.
//   The output register holds a finished beat while the receiver stalls;
//   the next beat is accepted meanwhile and waits in its last state until
//   the register is taken.
//   Synchronous reset sets the window size to 15 and empties the window.
// ----------------------------------------------------------------------------
module sliding_window_rsi
  import swrsi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [WIN_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PRICE_W-1:0] in_close_price,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [Q_W-1:0]     out_rsi_value,
  output logic               out_rsi_valid
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  swrsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swrsi_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_close_price (in_close_price),
    .cmd            (cmd),
    .stat           (stat),
    .out_rsi_value  (out_rsi_value),
    .out_rsi_valid  (out_rsi_valid)
  );

endmodule

// File: design/swrsi_ctrl.sv
// ----------------------------------------------------------------------------
// swrsi_ctrl - sequencer of the sliding window RSI block
// Walks each beat through ring read, sum update, scaling, the divider steps
// and the output register, and owns both handshakes.
// ----------------------------------------------------------------------------
module swrsi_ctrl
  import swrsi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  sw_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // state, step count and output flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = (stat.kind == RK_DIVIDE) ? ST_LOAD : ST_DONE;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  // an accepted beat always starts with the ring read
  a_accept_to_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_RD))
    else $error("accepted beat did not enter ring read");

  // the divider runs exactly its step count
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == CNT_W'(DIV_STEPS - 1)) |=> (state_r == ST_DONE))
    else $error("divider overran its step count");

  // a new result appears only when leaving the done state
  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("output valid rose outside the done state");

  // a stalled receiver keeps the finished result waiting
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_ready) |=> (state_r == ST_DONE))
    else $error("result overwrote an untaken beat");

endmodule

// File: design/swrsi_dpath.sv
// ----------------------------------------------------------------------------
// swrsi_dpath - datapath of the sliding window RSI block
// Delta ring memory, running gain and loss sums, scaling adder, restoring
// divider and the output register, driven by the sequencer's commands.
// ----------------------------------------------------------------------------
module swrsi_dpath
  import swrsi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [WIN_W-1:0]   cfg_wr_data,
  input  logic [PRICE_W-1:0] in_close_price,
  input  ctl_cmd_t           cmd,
  output dp_stat_t           stat,
  output logic [Q_W-1:0]     out_rsi_value,
  output logic               out_rsi_valid
);

  logic [DELTA_W-1:0] ring [RING_DEPTH];
  logic [DELTA_W-1:0] rd_data_r;

  logic [WIN_W-1:0]   window_r;
  logic [FILL_W-1:0]  fill_r;
  logic [PTR_W-1:0]   ptr_r;
  logic [SUM_W-1:0]   gain_r, loss_r;
  logic [PRICE_W-1:0] prev_r, close_r;

  logic [P_W-1:0]     p_r;
  logic [SUM_W-1:0]   tot_r;
  logic [SUM_W-1:0]   rem_r;
  logic [Q_W-1:0]     quo_r;

  logic [Q_W-1:0]     out_value_r;
  logic               out_valid_r;

  // effective window and oldest live slot
  logic [EFF_W-1:0]   eff;
  logic               eff_lt2;
  logic [PTR_W-1:0]   back;
  logic [PTR_W-1:0]   oldest;

  always_comb begin
    eff = (EFF_W'(window_r) > EFF_W'(MAX_WINDOW)) ? EFF_W'(MAX_WINDOW) : EFF_W'(window_r);
    eff_lt2 = (eff < EFF_W'(2));
    back = PTR_W'(eff - EFF_W'(1));
    if (ptr_r >= back) begin
      oldest = ptr_r - back;
    end else begin
      oldest = PTR_W'((PTR_W + 1)'(ptr_r) + (PTR_W + 1)'(RING_DEPTH) - (PTR_W + 1)'(back));
    end
  end

  // new delta and the magnitudes that enter and leave the sums
  logic [DELTA_W-1:0] delta;
  logic [DELTA_W-1:0] old_neg;
  logic               new_gain, old_gain, full_win;
  logic [PRICE_W-1:0] new_mag, old_mag;
  logic [SUM_W-1:0]   gain_upd, loss_upd;

  always_comb begin
    delta    = {1'b0, close_r} - {1'b0, prev_r};
    new_gain = (close_r > prev_r);
    new_mag  = new_gain ? (close_r - prev_r) : (prev_r - close_r);
    old_neg  = -rd_data_r;
    old_gain = !rd_data_r[DELTA_W-1] && (rd_data_r != '0);
    old_mag  = rd_data_r[DELTA_W-1] ? old_neg[PRICE_W-1:0] : rd_data_r[PRICE_W-1:0];
    full_win = (EFF_W'(fill_r) >= eff);
    gain_upd = gain_r;
    loss_upd = loss_r;
    // drop the oldest delta once the window is full
    if (full_win) begin
      if (old_gain) begin
        gain_upd = gain_upd - SUM_W'(old_mag);
      end else begin
        loss_upd = loss_upd - SUM_W'(old_mag);
      end
    end
    if (new_gain) begin
      gain_upd = gain_upd + SUM_W'(new_mag);
    end else begin
      loss_upd = loss_upd + SUM_W'(new_mag);
    end
  end

  // delta ring: write at the pointer, registered read of the oldest slot
  logic ring_we;
  assign ring_we = cmd.update && !eff_lt2 && (fill_r != '0);

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ptr_r] <= delta;
    end
    rd_data_r <= ring[oldest];
  end

  // window state: config clears it, an update advances it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      fill_r   <= '0;
      ptr_r    <= '0;
      gain_r   <= '0;
      loss_r   <= '0;
      prev_r   <= '0;
    end else if (cfg_wr_en) begin
      window_r <= cfg_wr_data;
      fill_r   <= '0;
      ptr_r    <= '0;
      gain_r   <= '0;
      loss_r   <= '0;
    end else if (cmd.update) begin
      prev_r <= close_r;
      if (eff_lt2) begin
        fill_r <= FILL_W'(eff);
      end else if (fill_r == '0) begin
        fill_r <= FILL_W'(1);
      end else begin
        fill_r <= full_win ? FILL_W'(eff) : fill_r + 1'b1;
        ptr_r  <= (ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
        gain_r <= gain_upd;
        loss_r <= loss_upd;
      end
    end
  end

  // classify the result from the updated window
  always_comb begin
    if (fill_r < FILL_W'(2)) begin
      stat.kind = RK_INVALID;
    end else if (loss_r == '0) begin
      stat.kind = RK_FULL;
    end else if (gain_r == '0) begin
      stat.kind = RK_ZERO;
    end else begin
      stat.kind = RK_DIVIDE;
    end
  end

  // scaling and restoring division, one quotient bit per step
  logic [NUM_W-1:0] num;
  logic [SUM_W:0]   trial;
  logic             qbit;

  always_comb begin
    num   = {p_r, {FRAC_W{1'b0}}} + NUM_W'(tot_r >> 1);
    trial = {rem_r, quo_r[Q_W-1]};
    qbit  = (trial >= {1'b0, tot_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      close_r <= in_close_price;
    end
    if (cmd.prep) begin
      // gain * 100 as shifted adds
      p_r   <= (P_W'(gain_r) << 6) + (P_W'(gain_r) << 5) + (P_W'(gain_r) << 2);
      tot_r <= gain_r + loss_r;
    end
    if (cmd.load) begin
      rem_r <= num[NUM_W-1:Q_W];
      quo_r <= num[Q_W-1:0];
    end else if (cmd.step) begin
      rem_r <= qbit ? SUM_W'(trial - {1'b0, tot_r}) : SUM_W'(trial);
      quo_r <= {quo_r[Q_W-2:0], qbit};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_valid_r <= (stat.kind != RK_INVALID);
      case (stat.kind)
        RK_INVALID: out_value_r <= '0;
        RK_FULL:    out_value_r <= FULL_SCALE;
        RK_ZERO:    out_value_r <= '0;
        RK_DIVIDE:  out_value_r <= quo_r;
        default:    out_value_r <= '0;
      endcase
    end
  end

  assign out_rsi_value = out_value_r;
  assign out_rsi_valid = out_valid_r;

endmodule
